/* hdl/fvc_pkg.sv */
// Shared types, constants and lookup functions of the flow vector colorizer.
// Depends on nothing; every other file of the block refers to it by scoped names.
package fvc_pkg;

  localparam int FLOW_FRAC_BITS_DEF = 8;
  localparam int CORDIC_STEPS_DEF   = 16;
  localparam int ANG_PI             = 65536;
  localparam int ANG_W              = 20;
  localparam int INV_GAIN           = 39797;
  localparam int WHEEL_LEN          = 55;
  localparam int DIV_STEP_BITS      = 4;
  localparam int CFG_DATA_W         = 15;
  localparam int CFG_INDEX_W        = 3;

  localparam logic [1:0] MODE_WHEEL = 2'd0;
  localparam logic [1:0] MODE_HSV   = 2'd1;
  localparam logic [1:0] MODE_RED   = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_MOTION = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RED_THRESH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RED_GAIN   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_VALUE_GAIN = 3'd4;

  typedef struct packed {
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
    logic               flow_valid;
  } in_word_t;

  typedef struct packed {
    logic [7:0] chan_first;
    logic [7:0] chan_second;
    logic [7:0] chan_third;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [14:0] max_motion;
    logic [14:0] red_threshold;
    logic [7:0]  red_gain;
    logic [7:0]  value_gain;
  } cfg_t;

  // Per-item flags that travel alongside the datapath.
  typedef struct packed {
    logic flow_valid;
    logic y_zero;
    logic x_neg;
  } side_t;

  // atan(2^-i) / pi with 16 fraction bits.
  function automatic logic [15:0] atan_val(input int i);
    logic [15:0] v;
    case (i)
      0:  v = 16'd16384;
      1:  v = 16'd9672;
      2:  v = 16'd5110;
      3:  v = 16'd2594;
      4:  v = 16'd1302;
      5:  v = 16'd652;
      6:  v = 16'd326;
      7:  v = 16'd163;
      8:  v = 16'd81;
      9:  v = 16'd41;
      10: v = 16'd20;
      11: v = 16'd10;
      12: v = 16'd5;
      13: v = 16'd3;
      14: v = 16'd1;
      15: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // Colour wheel entry as {red, green, blue}.
  function automatic logic [23:0] wheel_rgb(input logic [5:0] k);
    logic [23:0] v;
    case (k)
      6'd0:  v = {8'd255, 8'd0,   8'd0};
      6'd1:  v = {8'd255, 8'd17,  8'd0};
      6'd2:  v = {8'd255, 8'd34,  8'd0};
      6'd3:  v = {8'd255, 8'd51,  8'd0};
      6'd4:  v = {8'd255, 8'd68,  8'd0};
      6'd5:  v = {8'd255, 8'd85,  8'd0};
      6'd6:  v = {8'd255, 8'd102, 8'd0};
      6'd7:  v = {8'd255, 8'd119, 8'd0};
      6'd8:  v = {8'd255, 8'd136, 8'd0};
      6'd9:  v = {8'd255, 8'd153, 8'd0};
      6'd10: v = {8'd255, 8'd170, 8'd0};
      6'd11: v = {8'd255, 8'd187, 8'd0};
      6'd12: v = {8'd255, 8'd204, 8'd0};
      6'd13: v = {8'd255, 8'd221, 8'd0};
      6'd14: v = {8'd255, 8'd238, 8'd0};
      6'd15: v = {8'd255, 8'd255, 8'd0};
      6'd16: v = {8'd213, 8'd255, 8'd0};
      6'd17: v = {8'd170, 8'd255, 8'd0};
      6'd18: v = {8'd128, 8'd255, 8'd0};
      6'd19: v = {8'd85,  8'd255, 8'd0};
      6'd20: v = {8'd43,  8'd255, 8'd0};
      6'd21: v = {8'd0,   8'd255, 8'd0};
      6'd22: v = {8'd0,   8'd255, 8'd63};
      6'd23: v = {8'd0,   8'd255, 8'd127};
      6'd24: v = {8'd0,   8'd255, 8'd191};
      6'd25: v = {8'd0,   8'd255, 8'd255};
      6'd26: v = {8'd0,   8'd232, 8'd255};
      6'd27: v = {8'd0,   8'd209, 8'd255};
      6'd28: v = {8'd0,   8'd186, 8'd255};
      6'd29: v = {8'd0,   8'd163, 8'd255};
      6'd30: v = {8'd0,   8'd140, 8'd255};
      6'd31: v = {8'd0,   8'd116, 8'd255};
      6'd32: v = {8'd0,   8'd93,  8'd255};
      6'd33: v = {8'd0,   8'd70,  8'd255};
      6'd34: v = {8'd0,   8'd47,  8'd255};
      6'd35: v = {8'd0,   8'd24,  8'd255};
      6'd36: v = {8'd0,   8'd0,   8'd255};
      6'd37: v = {8'd19,  8'd0,   8'd255};
      6'd38: v = {8'd39,  8'd0,   8'd255};
      6'd39: v = {8'd58,  8'd0,   8'd255};
      6'd40: v = {8'd78,  8'd0,   8'd255};
      6'd41: v = {8'd98,  8'd0,   8'd255};
      6'd42: v = {8'd117, 8'd0,   8'd255};
      6'd43: v = {8'd137, 8'd0,   8'd255};
      6'd44: v = {8'd156, 8'd0,   8'd255};
      6'd45: v = {8'd176, 8'd0,   8'd255};
      6'd46: v = {8'd196, 8'd0,   8'd255};
      6'd47: v = {8'd215, 8'd0,   8'd255};
      6'd48: v = {8'd235, 8'd0,   8'd255};
      6'd49: v = {8'd255, 8'd0,   8'd255};
      6'd50: v = {8'd255, 8'd0,   8'd213};
      6'd51: v = {8'd255, 8'd0,   8'd170};
      6'd52: v = {8'd255, 8'd0,   8'd128};
      6'd53: v = {8'd255, 8'd0,   8'd85};
      6'd54: v = {8'd255, 8'd0,   8'd43};
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/fvc_cordic.sv */
// Pipelined vectoring CORDIC: one register stage per iteration, then gain removal.
// Depends on fvc_pkg.
module fvc_cordic #(
  parameter int FLOW_FRAC_BITS = fvc_pkg::FLOW_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS   = fvc_pkg::CORDIC_STEPS_DEF,
  parameter int CW             = 35 - fvc_pkg::FLOW_FRAC_BITS_DEF,
  parameter int MW             = CW - 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  input  fvc_pkg::in_word_t               in_word,
  input  logic                            negate,
  output logic                            out_vld,
  output fvc_pkg::side_t                  out_side,
  output logic signed [fvc_pkg::ANG_W-1:0] out_ang,
  output logic [MW-1:0]                   out_mag
);

  localparam int SH = 16 - FLOW_FRAC_BITS;
  localparam int ZW = fvc_pkg::ANG_W;
  localparam int PW = CW + 16;

  logic signed [CW-1:0] x_r [0:CORDIC_STEPS];
  logic signed [CW-1:0] y_r [0:CORDIC_STEPS];
  logic signed [ZW-1:0] z_r [0:CORDIC_STEPS];
  fvc_pkg::side_t       side_r [0:CORDIC_STEPS];
  logic                 vld_r [0:CORDIC_STEPS];

  logic signed [CW-1:0] xs, ys, x0, y0;
  logic signed [ZW-1:0] z0;
  fvc_pkg::side_t       side0;

  // Scale to 16 fraction bits and fold the left half-plane onto the right one.
  always_comb begin
    xs = CW'(in_word.flow_x) <<< SH;
    ys = CW'(in_word.flow_y) <<< SH;
    if (negate) begin
      xs = -xs;
      ys = -ys;
    end
    if (xs < 0) begin
      x0 = -xs;
      y0 = -ys;
      z0 = (ys > 0) ? ZW'(fvc_pkg::ANG_PI) : -ZW'(fvc_pkg::ANG_PI);
    end else begin
      x0 = xs;
      y0 = ys;
      z0 = '0;
    end
    side0.flow_valid = in_word.flow_valid;
    side0.y_zero     = (in_word.flow_y == 16'sd0);
    side0.x_neg      = in_word.flow_x[15];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    x_r[0]    <= x0;
    y_r[0]    <= y0;
    z_r[0]    <= z0;
    side_r[0] <= side0;
  end

  genvar i;
  for (i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] da;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    assign da = ZW'(fvc_pkg::atan_val(i));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      side_r[i+1] <= side_r[i];
      if (y_r[i] > 0) begin
        x_r[i+1] <= x_r[i] + dx;
        y_r[i+1] <= y_r[i] - dy;
        z_r[i+1] <= z_r[i] + da;
      end else begin
        x_r[i+1] <= x_r[i] - dx;
        y_r[i+1] <= y_r[i] + dy;
        z_r[i+1] <= z_r[i] - da;
      end
    end
  end

  logic signed [ZW-1:0] zc;
  logic [PW-1:0]        prod;

  // The x register never goes negative after the fold, so the gain fix is unsigned.
  always_comb begin
    zc = z_r[CORDIC_STEPS];
    if (zc > ZW'(fvc_pkg::ANG_PI)) begin
      zc = ZW'(fvc_pkg::ANG_PI);
    end else if (zc < -ZW'(fvc_pkg::ANG_PI)) begin
      zc = -ZW'(fvc_pkg::ANG_PI);
    end
    prod = PW'(x_r[CORDIC_STEPS][CW-2:0]) * PW'(fvc_pkg::INV_GAIN) + PW'(32768);
  end

  logic                     vld_out_r;
  fvc_pkg::side_t           side_out_r;
  logic signed [ZW-1:0]     ang_out_r;
  logic [MW-1:0]            mag_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out_r <= 1'b0;
    end else begin
      vld_out_r <= vld_r[CORDIC_STEPS];
    end
    side_out_r <= side_r[CORDIC_STEPS];
    ang_out_r  <= zc;
    mag_out_r  <= prod[MW+15:16];
  end

  assign out_vld  = vld_out_r;
  assign out_side = side_out_r;
  assign out_ang  = ang_out_r;
  assign out_mag  = mag_out_r;

endmodule

/* hdl/fvc_div.sv */
// Pipelined restoring divider, DIV_STEP_BITS quotient bits per stage, with a sideband word.
// Depends on fvc_pkg.
module fvc_div #(
  parameter int NW   = 34,
  parameter int SW   = 8,
  parameter int DENW = fvc_pkg::CFG_DATA_W
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  logic [NW-1:0]   in_num,
  input  logic [SW-1:0]   in_side,
  input  logic [DENW-1:0] den,
  output logic            out_vld,
  output logic [NW-1:0]   out_quo,
  output logic [SW-1:0]   out_side
);

  localparam int SB  = fvc_pkg::DIV_STEP_BITS;
  localparam int NST = (NW + SB - 1) / SB;

  logic [DENW-1:0] rem_r  [1:NST];
  logic [NW-1:0]   qn_r   [1:NST];
  logic [SW-1:0]   side_r [1:NST];
  logic            vld_r  [1:NST];

  genvar s;
  for (s = 0; s < NST; s++) begin : g_stage
    logic [DENW-1:0] rin;
    logic [NW-1:0]   qin;
    logic [SW-1:0]   sin;
    logic            vin;
    logic [DENW-1:0] rem;
    logic [NW-1:0]   qn;

    if (s == 0) begin : g_first
      assign rin = '0;
      assign qin = in_num;
      assign sin = in_side;
      assign vin = in_vld;
    end else begin : g_next
      assign rin = rem_r[s];
      assign qin = qn_r[s];
      assign sin = side_r[s];
      assign vin = vld_r[s];
    end

    // The numerator shifts out at the top while quotient bits shift in below.
    always_comb begin
      logic [DENW:0] r2;
      rem = rin;
      qn  = qin;
      r2  = '0;
      for (int j = 0; j < SB; j++) begin
        if (s * SB + j < NW) begin
          r2 = {rem, qn[NW-1]};
          qn = {qn[NW-2:0], 1'b0};
          if (r2 >= {1'b0, den}) begin
            rem   = DENW'(r2 - {1'b0, den});
            qn[0] = 1'b1;
          end else begin
            rem = r2[DENW-1:0];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vin;
      end
      rem_r[s+1]  <= rem;
      qn_r[s+1]   <= qn;
      side_r[s+1] <= sin;
    end
  end

  assign out_vld  = vld_r[NST];
  assign out_quo  = qn_r[NST];
  assign out_side = side_r[NST];

endmodule

/* hdl/fvc_color.sv */
// Four-stage back end: wheel position, blend, saturation scaling and mode selection.
// Depends on fvc_pkg.
module fvc_color #(
  parameter int FLOW_FRAC_BITS = fvc_pkg::FLOW_FRAC_BITS_DEF,
  parameter int MW             = 34 - fvc_pkg::FLOW_FRAC_BITS_DEF,
  parameter int NW             = 34
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  input  fvc_pkg::side_t                   in_side,
  input  logic signed [fvc_pkg::ANG_W-1:0] in_ang,
  input  logic [MW-1:0]                    in_mag,
  input  logic [NW-1:0]                    in_rad,
  input  fvc_pkg::cfg_t                    cfg,
  output logic                             out_strobe,
  output fvc_pkg::out_word_t               out_word
);

  localparam int SH = 16 - FLOW_FRAC_BITS;
  localparam int ZW = fvc_pkg::ANG_W;
  localparam int GW = MW + 8;
  localparam logic [5:0] K_LAST = 6'(fvc_pkg::WHEEL_LEN - 1);

  // Stage A: angle fix-ups, wheel index, radius range, red threshold, gain and hue products.
  logic signed [ZW-1:0] ang_a;
  logic [17:0]          angp;
  logic [22:0]          fk;
  logic [5:0]           k0, k1;
  logic [7:0]           gain;
  logic [GW-1:0]        gp;
  logic [25:0]          hp;

  always_comb begin
    ang_a = in_ang;
    if (in_side.y_zero) begin
      if (cfg.mode == fvc_pkg::MODE_WHEEL) begin
        ang_a = in_side.x_neg ? '0 : -ZW'(fvc_pkg::ANG_PI);
      end else if (cfg.mode == fvc_pkg::MODE_HSV) begin
        ang_a = in_side.x_neg ? ZW'(fvc_pkg::ANG_PI) : '0;
      end
    end
    angp = 18'(ang_a + ZW'(fvc_pkg::ANG_PI));
    fk   = 23'(angp) * 23'(27);
    k0   = (fk[21:16] > K_LAST) ? K_LAST : fk[21:16];
    k1   = (k0 == K_LAST) ? 6'd0 : k0 + 6'd1;
    gain = (cfg.mode == fvc_pkg::MODE_HSV) ? cfg.value_gain : cfg.red_gain;
    gp   = GW'(in_mag) * GW'(gain);
    hp   = 26'(angp) * 26'(255);
  end

  logic        a_vld_r, a_fv_r, a_big_r, a_thr_r;
  logic [5:0]  a_k0_r, a_k1_r;
  logic [15:0] a_f_r;
  logic [16:0] a_rad_r;
  logic [7:0]  a_hue_r, a_gsat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
    end
    a_fv_r   <= in_side.flow_valid;
    a_big_r  <= (in_rad > NW'(65536));
    a_thr_r  <= (in_mag >= (MW'(cfg.red_threshold) << SH));
    a_k0_r   <= k0;
    a_k1_r   <= k1;
    a_f_r    <= fk[15:0];
    a_rad_r  <= in_rad[16:0];
    a_hue_r  <= hp[24:17];
    a_gsat_r <= (|gp[GW-1:24]) ? 8'd255 : gp[23:16];
  end

  // Stage B: linear blend of two neighbouring wheel entries, one lane per byte.
  logic [23:0] w0, w1;
  assign w0 = fvc_pkg::wheel_rgb(a_k0_r);
  assign w1 = fvc_pkg::wheel_rgb(a_k1_r);

  logic [23:0] b_s_r [0:2];
  logic        b_vld_r, b_fv_r, b_big_r, b_thr_r;
  logic [16:0] b_rad_r;
  logic [7:0]  b_hue_r, b_gsat_r;

  // Stage C: saturation scaling by radius, or the 0.75 scale beyond unit radius.
  logic [40:0] c_prod_r [0:2];
  logic [7:0]  c_alt_r  [0:2];
  logic        c_vld_r, c_fv_r, c_big_r, c_thr_r;
  logic [7:0]  c_hue_r, c_gsat_r;

  logic [7:0]  pix [0:2];

  genvar c;
  for (c = 0; c < 3; c++) begin : g_lane
    logic signed [8:0]  dc;
    logic signed [25:0] pr;
    logic signed [25:0] sum;
    logic [23:0]        t;
    logic [25:0]        s3;
    logic [40:0]        diff;

    assign dc  = $signed({1'b0, w1[8*c+7:8*c]}) - $signed({1'b0, w0[8*c+7:8*c]});
    assign pr  = 26'($signed({1'b0, a_f_r}) * dc);
    assign sum = $signed({2'b00, w0[8*c+7:8*c], 16'd0}) + pr;

    always_ff @(posedge clk) begin
      b_s_r[c] <= sum[23:0];
    end

    assign t  = 24'hFF0000 - b_s_r[c];
    assign s3 = 26'(b_s_r[c]) * 26'(3);

    always_ff @(posedge clk) begin
      c_prod_r[c] <= 41'(b_rad_r) * 41'(t);
      c_alt_r[c]  <= s3[25:18];
    end

    assign diff   = (41'(255) << 32) - c_prod_r[c];
    assign pix[c] = c_big_r ? c_alt_r[c] : diff[39:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
    b_fv_r   <= a_fv_r;
    b_big_r  <= a_big_r;
    b_thr_r  <= a_thr_r;
    b_rad_r  <= a_rad_r;
    b_hue_r  <= a_hue_r;
    b_gsat_r <= a_gsat_r;
    c_fv_r   <= b_fv_r;
    c_big_r  <= b_big_r;
    c_thr_r  <= b_thr_r;
    c_hue_r  <= b_hue_r;
    c_gsat_r <= b_gsat_r;
  end

  // Stage D: pick the bytes that the mode calls for.
  fvc_pkg::out_word_t word_nxt, word_r;
  logic               strobe_r;

  always_comb begin
    word_nxt = '0;
    if (c_fv_r) begin
      case (cfg.mode)
        fvc_pkg::MODE_WHEEL: begin
          word_nxt.chan_first  = pix[0];
          word_nxt.chan_second = pix[1];
          word_nxt.chan_third  = pix[2];
        end
        fvc_pkg::MODE_HSV: begin
          word_nxt.chan_first  = c_hue_r;
          word_nxt.chan_second = 8'd255;
          word_nxt.chan_third  = c_gsat_r;
        end
        fvc_pkg::MODE_RED: begin
          word_nxt.chan_third = c_thr_r ? c_gsat_r : 8'd0;
        end
        default: word_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= c_vld_r;
    end
    word_r <= word_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_word   = word_r;

endmodule

/* hdl/flow_vector_colorizer.sv */
// Flow vector colorizer top level: configuration registers and the pipeline chain.
// Depends on fvc_pkg, fvc_cordic, fvc_div and fvc_color.
//
// Usage: one flow vector word enters on in_word at each rising edge where start is
// high and busy is low. busy is never raised, so a new word may enter in every
// cycle. Each accepted word gives exactly one result word on out_word, marked by
// out_strobe for one cycle, in the order the inputs arrived.
// The localparam LATENCY spans the accept edge to the result edge. On the way a
// word passes the CORDIC, one register stage per iteration, then the restoring
// divider for the normalized radius, four quotient bits per stage, and then the
// colour back end. Throughput is one word per cycle.
// The configuration port writes a register whenever cfg_we is high; registers are
// meant to change only while no word is in flight. Indexes past the last register
// are ignored.
// A synchronous reset (rst_n low) restores the register defaults and clears every
// valid bit, so words in flight are dropped. The receiver has no way to stall the
// block: each result is shown for exactly one cycle and must be taken then.
module flow_vector_colorizer #(
  parameter int FLOW_FRAC_BITS = fvc_pkg::FLOW_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS   = fvc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  fvc_pkg::in_word_t                 in_word,
  output logic                              out_strobe,
  output fvc_pkg::out_word_t                out_word,
  input  logic                              cfg_we,
  input  logic [fvc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fvc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // CORDIC datapath width: scaled input plus the fold and the CORDIC gain growth.
  localparam int CW      = 35 - FLOW_FRAC_BITS;
  localparam int MW      = CW - 1;
  localparam int NW      = MW + FLOW_FRAC_BITS;
  localparam int ZW      = fvc_pkg::ANG_W;
  localparam int SIDE_W  = $bits(fvc_pkg::side_t);
  localparam int SW      = SIDE_W + ZW + MW;
  localparam int DIV_ST  = (NW + fvc_pkg::DIV_STEP_BITS - 1) / fvc_pkg::DIV_STEP_BITS;
  localparam int LATENCY = CORDIC_STEPS + 2 + DIV_ST + 4;

  // Configuration registers.
  fvc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode          <= fvc_pkg::MODE_WHEEL;
      cfg_r.max_motion    <= 15'd25600;
      cfg_r.red_threshold <= 15'd1664;
      cfg_r.red_gain      <= 8'd12;
      cfg_r.value_gain    <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        fvc_pkg::REG_MODE:       cfg_r.mode          <= cfg_data[1:0];
        fvc_pkg::REG_MAX_MOTION: cfg_r.max_motion    <= cfg_data;
        fvc_pkg::REG_RED_THRESH: cfg_r.red_threshold <= cfg_data;
        fvc_pkg::REG_RED_GAIN:   cfg_r.red_gain      <= cfg_data[7:0];
        fvc_pkg::REG_VALUE_GAIN: cfg_r.value_gain    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Every cycle can take a word; the pipeline never backs up.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Colour wheel mode looks at the vector pointing the other way.
  logic                 cor_vld;
  fvc_pkg::side_t       cor_side;
  logic signed [ZW-1:0] cor_ang;
  logic [MW-1:0]        cor_mag;

  fvc_cordic #(
    .FLOW_FRAC_BITS (FLOW_FRAC_BITS),
    .CORDIC_STEPS   (CORDIC_STEPS),
    .CW             (CW),
    .MW             (MW)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (accept),
    .in_word  (in_word),
    .negate   (cfg_r.mode == fvc_pkg::MODE_WHEEL),
    .out_vld  (cor_vld),
    .out_side (cor_side),
    .out_ang  (cor_ang),
    .out_mag  (cor_mag)
  );

  // Radius normalized by max_motion; a zero divisor counts as one.
  logic [fvc_pkg::CFG_DATA_W-1:0] den;
  logic [NW-1:0]                  div_num;
  logic [SW-1:0]                  div_side_in, div_side_out;
  logic                           div_vld;
  logic [NW-1:0]                  div_quo;

  assign den         = (cfg_r.max_motion == '0) ? 15'd1 : cfg_r.max_motion;
  assign div_num     = {cor_mag, {FLOW_FRAC_BITS{1'b0}}};
  assign div_side_in = {cor_side, cor_ang, cor_mag};

  fvc_div #(
    .NW   (NW),
    .SW   (SW),
    .DENW (fvc_pkg::CFG_DATA_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (cor_vld),
    .in_num   (div_num),
    .in_side  (div_side_in),
    .den      (den),
    .out_vld  (div_vld),
    .out_quo  (div_quo),
    .out_side (div_side_out)
  );

  fvc_pkg::side_t       col_side;
  logic signed [ZW-1:0] col_ang;
  logic [MW-1:0]        col_mag;

  assign col_side = fvc_pkg::side_t'(div_side_out[SW-1 -: SIDE_W]);
  assign col_ang  = $signed(div_side_out[MW+ZW-1:MW]);
  assign col_mag  = div_side_out[MW-1:0];

  fvc_color #(
    .FLOW_FRAC_BITS (FLOW_FRAC_BITS),
    .MW             (MW),
    .NW             (NW)
  ) u_color (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (div_vld),
    .in_side    (col_side),
    .in_ang     (col_ang),
    .in_mag     (col_mag),
    .in_rad     (div_quo),
    .cfg        (cfg_r),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

/* hdl/fvc_checker.sv */
// Port-level checker of the flow vector colorizer and the bind that attaches it.
// Depends on fvc_pkg and flow_vector_colorizer.
module fvc_checker #(
  parameter int LAT = 31
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input fvc_pkg::in_word_t         in_word,
  input logic                      out_strobe,
  input fvc_pkg::out_word_t        out_word
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_strobe)
    else $error("accepted word gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##LAT !out_strobe)
    else $error("result without a word");

  a_invalid_black: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_word.flow_valid) |-> ##LAT (out_word == '0))
    else $error("invalid vector not black");

endmodule

bind flow_vector_colorizer fvc_checker #(.LAT(LATENCY)) u_fvc_checker (.*);
